>>> src/lfwu_pkg.sv
// ----------------------------------------------------------------------------
// lfwu_pkg: shared definitions for the linear-function weight unit
// Operation codes, point tags and the default datapath width.
// ----------------------------------------------------------------------------
package lfwu_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;

   typedef enum logic [1:0] {
      OP_COMPOSE = 2'd0,
      OP_COMBINE = 2'd1,
      OP_EQUAL   = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      TAG_VAL  = 2'd0,
      TAG_NONE = 2'd1,
      TAG_BOT  = 2'd2,
      TAG_BAD  = 2'd3
   } tag_type;

endpackage

>>> src/linear_function_weight_unit.sv
// ----------------------------------------------------------------------------
// linear_function_weight_unit
// Composes, combines or compares two linear-function weights, fully pipelined.
// ----------------------------------------------------------------------------
// A request can enter every cycle while the pipeline advances, and passes
// through VALUE_WIDTH + 3 register stages: one input register, one stage per
// quotient bit of the exact-division check, one multiplier stage and the
// output register. The division pipeline makes up most of the stages; the
// throughput is one request per cycle unless a response is held. A stalled
// response holds the whole pipeline, so req_stall follows rsp_stall while a
// response is waiting.
module linear_function_weight_unit #(
   parameter int VALUE_WIDTH = lfwu_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_op,
   input  logic                   req_x_is_top,
   input  logic [VALUE_WIDTH-1:0] req_x_a,
   input  logic [VALUE_WIDTH-1:0] req_x_b,
   input  logic [VALUE_WIDTH-1:0] req_x_c,
   input  logic [1:0]             req_x_c_tag,
   input  logic                   req_y_is_top,
   input  logic [VALUE_WIDTH-1:0] req_y_a,
   input  logic [VALUE_WIDTH-1:0] req_y_b,
   input  logic [VALUE_WIDTH-1:0] req_y_c,
   input  logic [1:0]             req_y_c_tag,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_r_is_top,
   output logic [VALUE_WIDTH-1:0] rsp_r_a,
   output logic [VALUE_WIDTH-1:0] rsp_r_b,
   output logic [VALUE_WIDTH-1:0] rsp_r_c,
   output logic [1:0]             rsp_r_c_tag,
   output logic                   rsp_equal
);

   localparam int W = VALUE_WIDTH;

   typedef struct packed {
      logic [1:0]   tag;
      logic [W-1:0] v;
   } point_type;

   typedef struct packed {
      logic         top;
      logic [W-1:0] a;
      logic [W-1:0] b;
      point_type    c;
   } weight_type;

   typedef struct packed {
      logic [1:0]   op;
      weight_type   x;
      weight_type   y;
      logic         q_neg;
      logic         den_zero;
      logic [W-1:0] md;
      logic [W-1:0] rem;
      logic [W-1:0] dq;
   } div_type;

   typedef struct packed {
      logic [1:0]   op;
      weight_type   x;
      weight_type   y;
      logic         exact;
      logic [W-1:0] ta;
      logic [W-1:0] tb;
      logic [W-1:0] ta_q;
      logic [W-1:0] ya_xc;
      logic [W-1:0] ya_xa;
      logic [W-1:0] ya_xb;
   } mul_type;

   function automatic point_type mk_pt(input logic [1:0] tag, input logic [W-1:0] v);
      point_type p;
      p.tag = tag;
      p.v   = (tag == lfwu_pkg::TAG_VAL) ? v : '0;
      return p;
   endfunction

   function automatic weight_type decode(input logic top, input logic [W-1:0] a,
                                         input logic [W-1:0] b, input logic [W-1:0] c,
                                         input logic [1:0] tag);
      weight_type w;
      logic [1:0] t;
      t     = (tag == lfwu_pkg::TAG_BAD) ? lfwu_pkg::TAG_BOT : tag;
      w.top = top;
      w.a   = a;
      w.b   = b;
      w.c   = mk_pt(t, c);
      return w;
   endfunction

   function automatic point_type meet(input point_type p, input point_type q);
      point_type r;
      if (p.tag == q.tag && (p.tag != lfwu_pkg::TAG_VAL || p.v == q.v)) begin
         r = p;
      end else if (p.tag == lfwu_pkg::TAG_NONE) begin
         r = q;
      end else if (q.tag == lfwu_pkg::TAG_NONE) begin
         r = p;
      end else begin
         r = mk_pt(lfwu_pkg::TAG_BOT, '0);
      end
      return r;
   endfunction

   function automatic weight_type mk_top();
      weight_type w;
      w.top = 1'b1;
      w.a   = '0;
      w.b   = '0;
      w.c   = mk_pt(lfwu_pkg::TAG_NONE, '0);
      return w;
   endfunction

   function automatic weight_type mk_bottom();
      weight_type w;
      w.top = 1'b0;
      w.a   = W'(1);
      w.b   = '0;
      w.c   = mk_pt(lfwu_pkg::TAG_BOT, '0);
      return w;
   endfunction

   function automatic weight_type normalise(input logic [W-1:0] a, input logic [W-1:0] b,
                                            input point_type c);
      weight_type w;
      w.top = 1'b0;
      w.a   = a;
      w.b   = b;
      w.c   = c;
      if (c.tag == lfwu_pkg::TAG_BOT) begin
         w = mk_bottom();
      end else if (a == '0 && c.tag == lfwu_pkg::TAG_VAL) begin
         if (b != c.v) begin
            w = mk_bottom();
         end else begin
            w.c = mk_pt(lfwu_pkg::TAG_NONE, '0);
         end
      end
      return w;
   endfunction

   // One restoring division step, most significant bit first.
   function automatic div_type div_step(input div_type d);
      div_type    s;
      logic [W:0] trial;
      logic       qbit;
      s     = d;
      trial = {d.rem, d.dq[W-1]};
      qbit  = (trial >= {1'b0, d.md});
      s.rem = qbit ? W'(trial - {1'b0, d.md}) : trial[W-1:0];
      s.dq  = {d.dq[W-2:0], qbit};
      return s;
   endfunction

   // The whole pipeline advances together unless a response is held.
   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // Input stage: decode and set up the magnitude division.
   div_type      div_ff [0:W];
   logic [W:0]   div_vld_ff;
   div_type      div_in0;
   logic [W-1:0] num, den;

   always_comb begin
      div_in0.op       = req_op;
      div_in0.x        = decode(req_x_is_top, req_x_a, req_x_b, req_x_c, req_x_c_tag);
      div_in0.y        = decode(req_y_is_top, req_y_a, req_y_b, req_y_c, req_y_c_tag);
      num              = req_x_b - req_y_b;
      den              = req_y_a - req_x_a;
      div_in0.q_neg    = num[W-1] ^ den[W-1];
      div_in0.den_zero = (den == '0);
      div_in0.md       = den[W-1] ? W'(-den) : den;
      div_in0.dq       = num[W-1] ? W'(-num) : num;
      div_in0.rem      = '0;
   end

   // Input register followed by one division stage per quotient bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff <= '0;
      end else if (advance) begin
         div_vld_ff <= {div_vld_ff[W-1:0], req_valid};
      end
      if (advance) begin
         div_ff[0] <= div_in0;
         for (int k = 1; k <= W; k++) begin
            div_ff[k] <= div_step(div_ff[k-1]);
         end
      end
   end

   // Multiplier stage.
   mul_type      mul_ff, mul_in;
   logic         mul_vld_ff;
   logic [W-1:0] q;
   div_type      dd;

   always_comb begin
      dd            = div_ff[W];
      q             = dd.q_neg ? W'(-dd.dq) : dd.dq;
      mul_in.op     = dd.op;
      mul_in.x      = dd.x;
      mul_in.y      = dd.y;
      mul_in.exact  = !dd.den_zero && (dd.rem == '0);
      if ($signed(dd.x.a) <= $signed(dd.y.a)) begin
         mul_in.ta = dd.x.a;
         mul_in.tb = dd.x.b;
      end else begin
         mul_in.ta = dd.y.a;
         mul_in.tb = dd.y.b;
      end
      mul_in.ta_q  = W'(mul_in.ta * q);
      mul_in.ya_xc = W'(dd.y.a * dd.x.c.v);
      mul_in.ya_xa = W'(dd.y.a * dd.x.a);
      mul_in.ya_xb = W'(dd.y.a * dd.x.b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else if (advance) begin
         mul_vld_ff <= div_vld_ff[W];
      end
      if (advance) begin
         mul_ff <= mul_in;
      end
   end

   // Output stage: final adds, meets and normalisation.
   weight_type res;
   logic       eq;
   point_type  p;
   weight_type x, y;

   always_comb begin
      x   = mul_ff.x;
      y   = mul_ff.y;
      res = '0;
      eq  = 1'b0;
      p   = x.c;
      case (mul_ff.op)
         lfwu_pkg::OP_COMPOSE: begin
            if (x.top || y.top) begin
               res = mk_top();
            end else begin
               if (x.c.tag == lfwu_pkg::TAG_VAL) begin
                  p = mk_pt(lfwu_pkg::TAG_VAL, mul_ff.ya_xc + y.b);
               end
               res = normalise(mul_ff.ya_xa, mul_ff.ya_xb + y.b, meet(p, y.c));
            end
         end
         lfwu_pkg::OP_COMBINE: begin
            if (x.top) begin
               res = y;
            end else if (y.top) begin
               res = x;
            end else if (x.a == y.a && x.b == y.b) begin
               res = normalise(x.a, x.b, meet(x.c, y.c));
            end else if (!mul_ff.exact) begin
               res = mk_bottom();
            end else if (x.a == '0 && y.a != '0) begin
               res = normalise(y.a, y.b, mk_pt(lfwu_pkg::TAG_VAL, x.b));
            end else if (y.a == '0 && x.a != '0) begin
               res = normalise(x.a, x.b, mk_pt(lfwu_pkg::TAG_VAL, y.b));
            end else begin
               res = normalise(mul_ff.ta, mul_ff.tb,
                               meet(mk_pt(lfwu_pkg::TAG_VAL, mul_ff.ta_q + mul_ff.tb),
                                    meet(x.c, y.c)));
            end
         end
         lfwu_pkg::OP_EQUAL: begin
            if (x.top || y.top) begin
               eq = x.top && y.top;
            end else if (x.c.tag == lfwu_pkg::TAG_BOT || y.c.tag == lfwu_pkg::TAG_BOT) begin
               eq = (x.c.tag == lfwu_pkg::TAG_BOT) && (y.c.tag == lfwu_pkg::TAG_BOT);
            end else if (x.a == y.a && x.b == y.b && x.c == y.c) begin
               eq = 1'b1;
            end else if (x.a == '0 || y.a == '0) begin
               eq = 1'b0;
            end else begin
               eq = (x.c.tag == lfwu_pkg::TAG_VAL) && (y.c.tag == lfwu_pkg::TAG_VAL)
                    && mul_ff.exact;
            end
         end
         default: begin
            res = '0;
         end
      endcase
   end

   logic       rsp_valid_ff;
   weight_type rsp_res_ff;
   logic       rsp_equal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mul_vld_ff;
      end
      if (advance) begin
         rsp_res_ff   <= res;
         rsp_equal_ff <= eq;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_r_is_top = rsp_res_ff.top;
   assign rsp_r_a      = rsp_res_ff.a;
   assign rsp_r_b      = rsp_res_ff.b;
   assign rsp_r_c      = rsp_res_ff.c.v;
   assign rsp_r_c_tag  = rsp_res_ff.c.tag;
   assign rsp_equal    = rsp_equal_ff;

endmodule

>>> src/lfwu_checker.sv
// ----------------------------------------------------------------------------
// lfwu_checker
// Port-level checks for the linear-function weight unit, bound to the top.
// ----------------------------------------------------------------------------
module lfwu_checker #(
   parameter int VALUE_WIDTH = lfwu_pkg::VALUE_WIDTH_DEFAULT
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic                   rsp_r_is_top,
   input logic [VALUE_WIDTH-1:0] rsp_r_a,
   input logic [VALUE_WIDTH-1:0] rsp_r_b,
   input logic [VALUE_WIDTH-1:0] rsp_r_c,
   input logic [1:0]             rsp_r_c_tag,
   input logic                   rsp_equal
);

   // A held response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // The input is only held off while a response is waiting.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with no response waiting");

   // An equality answer carries an all-zero weight.
   a_equal_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_equal |-> !rsp_r_is_top && rsp_r_c_tag == lfwu_pkg::TAG_VAL
                                 && rsp_r_a == '0 && rsp_r_b == '0 && rsp_r_c == '0)
      else $error("equality response carries weight fields");

   // A top result never comes with an equality answer.
   a_top_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_r_is_top |-> !rsp_equal)
      else $error("malformed top result");

   // A point value only appears with a value tag, and the spare tag never does.
   a_point_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_r_c_tag != lfwu_pkg::TAG_BAD
                    && (rsp_r_c_tag == lfwu_pkg::TAG_VAL || rsp_r_c == '0))
      else $error("malformed result point");

endmodule

bind linear_function_weight_unit lfwu_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_lfwu_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_r_is_top (rsp_r_is_top),
   .rsp_r_a      (rsp_r_a),
   .rsp_r_b      (rsp_r_b),
   .rsp_r_c      (rsp_r_c),
   .rsp_r_c_tag  (rsp_r_c_tag),
   .rsp_equal    (rsp_equal)
);

>>> dv/linear_function_weight_unit_test.sv
// ----------------------------------------------------------------------------
// linear_function_weight_unit_test: self-checking bench for the weight unit
// Drives all four operation codes with random idling on both sides,
// predicts each response in the bench and compares it field by field.
// ----------------------------------------------------------------------------
module linear_function_weight_unit_test;

   localparam int W = 32;
   localparam int LATENCY = W + 3;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]   op;
      logic         x_top;
      logic [W-1:0] xa, xb, xc;
      logic [1:0]   xt;
      logic         y_top;
      logic [W-1:0] ya, yb, yc;
      logic [1:0]   yt;
   } request_type;

   typedef struct packed {
      logic         top;
      logic [W-1:0] a, b, c;
      logic [1:0]   tag;
      logic         eq;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_op = '0;
   logic req_x_is_top = 1'b0, req_y_is_top = 1'b0;
   logic [W-1:0] req_x_a = '0, req_x_b = '0, req_x_c = '0;
   logic [W-1:0] req_y_a = '0, req_y_b = '0, req_y_c = '0;
   logic [1:0] req_x_c_tag = '0, req_y_c_tag = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_r_is_top, rsp_equal;
   logic [W-1:0] rsp_r_a, rsp_r_b, rsp_r_c;
   logic [1:0] rsp_r_c_tag;

   request_type pending_requests[$];
   result_type  expected_weights[$];
   int          failures = 0;
   int          send_idle_pct = 16;
   int          recv_idle_pct = 88;
   int          hold_off = 0;
   int          quiet_cycles = 0;

   linear_function_weight_unit #(.VALUE_WIDTH(W)) i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic result_type point(logic [1:0] tag, logic [W-1:0] v);
      result_type p;
      p = '0;
      p.tag = tag;
      p.c = (tag == lfwu_pkg::TAG_VAL) ? v : '0;
      return p;
   endfunction

   function automatic result_type bottom_weight();
      result_type w;
      w = point(lfwu_pkg::TAG_BOT, '0);
      w.a = 1;
      return w;
   endfunction

   function automatic result_type decode_weight(logic top, logic [W-1:0] a, logic [W-1:0] b,
                                                logic [W-1:0] c, logic [1:0] tag);
      result_type w;
      w = point((tag == lfwu_pkg::TAG_BAD) ? lfwu_pkg::TAG_BOT : tag, c);
      w.top = top;
      w.a = a;
      w.b = b;
      return w;
   endfunction

   // Meet of two points; only tag and c are meaningful.
   function automatic result_type meet_point(result_type p, result_type q);
      if (p.tag == q.tag && (p.tag != lfwu_pkg::TAG_VAL || p.c == q.c))
         return point(p.tag, p.c);
      if (p.tag == lfwu_pkg::TAG_NONE) return point(q.tag, q.c);
      if (q.tag == lfwu_pkg::TAG_NONE) return point(p.tag, p.c);
      return point(lfwu_pkg::TAG_BOT, '0);
   endfunction

   function automatic result_type normalised(logic [W-1:0] a, logic [W-1:0] b,
                                             result_type p);
      result_type w;
      if (p.tag == lfwu_pkg::TAG_BOT) return bottom_weight();
      w = point(p.tag, p.c);
      if (a == 0 && p.tag == lfwu_pkg::TAG_VAL) begin
         if (b != p.c) return bottom_weight();
         w = point(lfwu_pkg::TAG_NONE, '0);
      end
      w.a = a;
      w.b = b;
      return w;
   endfunction

   function automatic bit exact_quotient(logic [W-1:0] num, logic [W-1:0] den,
                                         output logic [W-1:0] q);
      logic [W-1:0] mn, md, mq;
      mn = num[W-1] ? -num : num;
      md = den[W-1] ? -den : den;
      q = '0;
      if (den == 0) return 1'b0;
      if (mn % md != 0) return 1'b0;
      mq = mn / md;
      q = (num[W-1] ^ den[W-1]) ? -mq : mq;
      return 1'b1;
   endfunction

   function automatic result_type composed(result_type x, result_type y);
      result_type p, t;
      t = '0;
      t.top = 1'b1;
      t.tag = lfwu_pkg::TAG_NONE;
      if (x.top || y.top) return t;
      p = (x.tag == lfwu_pkg::TAG_VAL) ? point(lfwu_pkg::TAG_VAL, y.a * x.c + y.b)
                                       : point(x.tag, x.c);
      return normalised(y.a * x.a, y.a * x.b + y.b, meet_point(p, y));
   endfunction

   function automatic result_type combined(result_type x, result_type y);
      logic [W-1:0] q, ta, tb;
      if (x.top) return y;
      if (y.top) return x;
      if (x.a == y.a && x.b == y.b) return normalised(x.a, x.b, meet_point(x, y));
      if (!exact_quotient(x.b - y.b, y.a - x.a, q)) return bottom_weight();
      if (x.a == 0 && y.a != 0) return normalised(y.a, y.b, point(lfwu_pkg::TAG_VAL, x.b));
      if (y.a == 0 && x.a != 0) return normalised(x.a, x.b, point(lfwu_pkg::TAG_VAL, y.b));
      if ($signed(x.a) <= $signed(y.a)) begin
         ta = x.a;
         tb = x.b;
      end else begin
         ta = y.a;
         tb = y.b;
      end
      return normalised(ta, tb, meet_point(point(lfwu_pkg::TAG_VAL, ta * q + tb),
                                           meet_point(x, y)));
   endfunction

   function automatic bit weights_match(result_type x, result_type y);
      logic [W-1:0] q;
      if (x.top || y.top) return x.top && y.top;
      if (x.tag == lfwu_pkg::TAG_BOT || y.tag == lfwu_pkg::TAG_BOT)
         return x.tag == lfwu_pkg::TAG_BOT && y.tag == lfwu_pkg::TAG_BOT;
      if (x.a == y.a && x.b == y.b && x.tag == y.tag && x.c == y.c) return 1'b1;
      if (x.a == 0 || y.a == 0) return 1'b0;
      if (x.tag == lfwu_pkg::TAG_VAL && y.tag == lfwu_pkg::TAG_VAL)
         return exact_quotient(x.b - y.b, y.a - x.a, q);
      return 1'b0;
   endfunction

   function automatic result_type predicted_response(request_type r);
      result_type x, y, res;
      x = decode_weight(r.x_top, r.xa, r.xb, r.xc, r.xt);
      y = decode_weight(r.y_top, r.ya, r.yb, r.yc, r.yt);
      res = '0;
      case (lfwu_pkg::op_type'(r.op))
         lfwu_pkg::OP_COMPOSE: res = composed(x, y);
         lfwu_pkg::OP_COMBINE: res = combined(x, y);
         lfwu_pkg::OP_EQUAL:   res.eq = weights_match(x, y);
         default:              res = '0;
      endcase
      return res;
   endfunction

   function automatic logic [W-1:0] random_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 1;
         2: return '1;
         3: return {1'b1, {(W-1){1'b0}}};
         4: return {1'b0, {(W-1){1'b1}}};
         5: return W'($urandom_range(0, 8)) - 4;
         default: return $urandom;
      endcase
   endfunction

   // Random request with small values often, so that divisions come out exact.
   function automatic request_type random_request();
      request_type r;
      r.op = ($urandom_range(0, 19) == 0) ? lfwu_pkg::OP_UNUSED : 2'($urandom_range(0, 2));
      r.x_top = ($urandom_range(0, 9) == 0);
      r.y_top = ($urandom_range(0, 9) == 0);
      r.xa = random_value();
      r.xb = random_value();
      r.xc = random_value();
      r.ya = ($urandom_range(0, 3) == 0) ? r.xa : random_value();
      r.yb = ($urandom_range(0, 3) == 0) ? r.xb : random_value();
      r.yc = ($urandom_range(0, 3) == 0) ? r.xc : random_value();
      if ($urandom_range(0, 3) == 0) r.yc = r.yb;
      r.xt = ($urandom_range(0, 9) == 0) ? lfwu_pkg::TAG_BAD : 2'($urandom_range(0, 2));
      r.yt = ($urandom_range(0, 9) == 0) ? lfwu_pkg::TAG_BAD : 2'($urandom_range(0, 2));
      return r;
   endfunction

   function automatic request_type directed_request(logic [1:0] op, logic [W-1:0] xa,
                                                    logic [W-1:0] xb, logic [W-1:0] xc,
                                                    logic [1:0] xt, logic [W-1:0] ya,
                                                    logic [W-1:0] yb, logic [W-1:0] yc,
                                                    logic [1:0] yt);
      request_type r;
      r = '{op, 1'b0, xa, xb, xc, xt, 1'b0, ya, yb, yc, yt};
      return r;
   endfunction

   // Driver: one request is offered at a time, held while the block stalls it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) expected_weights.push_back(predicted_response(
            {req_op, req_x_is_top, req_x_a, req_x_b, req_x_c, req_x_c_tag,
             req_y_is_top, req_y_a, req_y_b, req_y_c, req_y_c_tag}));
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               request_type r;
               r = pending_requests.pop_front();
               req_valid <= 1'b1;
               {req_op, req_x_is_top, req_x_a, req_x_b, req_x_c, req_x_c_tag,
                req_y_is_top, req_y_a, req_y_b, req_y_c, req_y_c_tag} <= r;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor and receiver stall, including the long hold-off.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_weights.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               result_type e;
               e = expected_weights.pop_front();
               if (rsp_r_is_top !== e.top) begin
                  $error("r_is_top expected %0h got %0h", e.top, rsp_r_is_top);
                  failures++;
               end
               if (rsp_r_a !== e.a) begin
                  $error("r_a expected %0h got %0h", e.a, rsp_r_a);
                  failures++;
               end
               if (rsp_r_b !== e.b) begin
                  $error("r_b expected %0h got %0h", e.b, rsp_r_b);
                  failures++;
               end
               if (rsp_r_c !== e.c) begin
                  $error("r_c expected %0h got %0h", e.c, rsp_r_c);
                  failures++;
               end
               if (rsp_r_c_tag !== e.tag) begin
                  $error("r_c_tag expected %0h got %0h", e.tag, rsp_r_c_tag);
                  failures++;
               end
               if (rsp_equal !== e.eq) begin
                  $error("equal expected %0h got %0h", e.eq, rsp_equal);
                  failures++;
               end
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // Watchdog on cycles with no request or response accepted.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL linear_function_weight_unit");
         $finish;
      end
   end

   task automatic drain();
      wait (pending_requests.size() == 0);
      @(posedge clock);
      while (req_valid || expected_weights.size() > 0) @(posedge clock);
   endtask

   initial begin
      logic [W-1:0] mn, mx;
      request_type r;
      mn = {1'b1, {(W-1){1'b0}}};
      mx = {1'b0, {(W-1){1'b1}}};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      pending_requests.push_back(directed_request(lfwu_pkg::OP_COMPOSE, 2, 3, 5,
                                                  lfwu_pkg::TAG_VAL, 4, 1, 23,
                                                  lfwu_pkg::TAG_VAL));
      pending_requests.push_back(directed_request(lfwu_pkg::OP_COMPOSE, mx, mn, '1,
                                                  lfwu_pkg::TAG_NONE, mx, mx, 0,
                                                  lfwu_pkg::TAG_NONE));
      pending_requests.push_back(directed_request(lfwu_pkg::OP_COMPOSE, 0, 7, 7,
                                                  lfwu_pkg::TAG_VAL, 1, 0, 0,
                                                  lfwu_pkg::TAG_NONE));
      pending_requests.push_back(directed_request(lfwu_pkg::OP_COMPOSE, 0, 7, 8,
                                                  lfwu_pkg::TAG_VAL, 1, 0, 0,
                                                  lfwu_pkg::TAG_NONE));
      pending_requests.push_back(directed_request(lfwu_pkg::OP_COMPOSE, 1, 2, 0,
                                                  lfwu_pkg::TAG_BAD, 1, 2, 0,
                                                  lfwu_pkg::TAG_NONE));
      pending_requests.push_back(directed_request(lfwu_pkg::OP_COMBINE, 1, 0, 0,
                                                  lfwu_pkg::TAG_NONE, 3, 4, 0,
                                                  lfwu_pkg::TAG_NONE));
      pending_requests.push_back(directed_request(lfwu_pkg::OP_COMBINE, 1, 0, 0,
                                                  lfwu_pkg::TAG_NONE, 3, 3, 0,
                                                  lfwu_pkg::TAG_NONE));
      pending_requests.push_back(directed_request(lfwu_pkg::OP_COMBINE, 2, 2, 0,
                                                  lfwu_pkg::TAG_NONE, 2, 2, 9,
                                                  lfwu_pkg::TAG_VAL));
      pending_requests.push_back(directed_request(lfwu_pkg::OP_COMBINE, 0, 5, 0,
                                                  lfwu_pkg::TAG_NONE, 1, 0, 0,
                                                  lfwu_pkg::TAG_NONE));
      pending_requests.push_back(directed_request(lfwu_pkg::OP_COMBINE, 2, 0, 0,
                                                  lfwu_pkg::TAG_NONE, 0, 6, 0,
                                                  lfwu_pkg::TAG_NONE));
      pending_requests.push_back(directed_request(lfwu_pkg::OP_COMBINE, mn, 0, 0,
                                                  lfwu_pkg::TAG_NONE, '1, mn, 0,
                                                  lfwu_pkg::TAG_NONE));
      pending_requests.push_back(directed_request(lfwu_pkg::OP_COMBINE, 4, 0, 1,
                                                  lfwu_pkg::TAG_BOT, 4, 0, 1,
                                                  lfwu_pkg::TAG_BOT));
      pending_requests.push_back(directed_request(lfwu_pkg::OP_EQUAL, 1, 0, 0,
                                                  lfwu_pkg::TAG_VAL, 3, 4, 2,
                                                  lfwu_pkg::TAG_VAL));
      pending_requests.push_back(directed_request(lfwu_pkg::OP_EQUAL, 1, 0, 0,
                                                  lfwu_pkg::TAG_BOT, 5, 5, 0,
                                                  lfwu_pkg::TAG_BAD));
      pending_requests.push_back(directed_request(lfwu_pkg::OP_EQUAL, 2, 1, 3,
                                                  lfwu_pkg::TAG_NONE, 2, 1, 3,
                                                  lfwu_pkg::TAG_NONE));
      pending_requests.push_back(directed_request(lfwu_pkg::OP_UNUSED, mx, mx, mx,
                                                  lfwu_pkg::TAG_VAL, mn, mn, mn,
                                                  lfwu_pkg::TAG_VAL));
      r = directed_request(lfwu_pkg::OP_COMBINE, 9, 9, 9, lfwu_pkg::TAG_VAL,
                           1, 2, 0, lfwu_pkg::TAG_NONE);
      r.x_top = 1'b1;
      pending_requests.push_back(r);
      r.op = lfwu_pkg::OP_EQUAL;
      r.y_top = 1'b1;
      pending_requests.push_back(r);
      r.op = lfwu_pkg::OP_COMPOSE;
      r.x_top = 1'b0;
      pending_requests.push_back(r);
      drain();

      repeat (150) pending_requests.push_back(random_request());
      wait (pending_requests.size() < 100);
      hold_off = 300;
      drain();

      send_idle_pct = 88;
      recv_idle_pct = 16;
      repeat (150) pending_requests.push_back(random_request());
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (150) pending_requests.push_back(random_request());
      drain();

      repeat (LATENCY + 10) @(posedge clock);
      if (failures == 0 && expected_weights.size() == 0)
         $display("PASS linear_function_weight_unit");
      else
         $display("FAIL linear_function_weight_unit");
      $finish;
   end
endmodule
